FILE: hdl/sed_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sleep-entry decision block.
// No dependencies; the cfg, eval, fin and core files import this package.
package sed_pkg;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned MS_LIM_W   = 26;   // 65535 * 1000 fits in 26 bits
	localparam int unsigned SECS_W     = 17;
	localparam int unsigned WAKE_W     = 36;

	localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd300;
	localparam logic [15:0] DISP_OFF_RST     = 16'd60;

	localparam logic [SECS_W-1:0] WAKE_MARGIN_S  = 17'd15;
	localparam logic [SECS_W-1:0] WORTH_MIN_S    = 17'd135;  // margin plus 120 s
	localparam logic [SECS_W-1:0] WAKE_FLOOR_S   = 17'd5;
	localparam logic [SECS_W-1:0] FALLBACK_MIN_S = 17'd900;
	localparam logic signed [19:0] DAY_S         = 20'sd86400;

	// Reciprocal of 1000 scaled by 2^38; exact for every 32-bit dividend.
	localparam logic [28:0] RECIP_1000 = 29'd274877907;
	localparam int unsigned RECIP_SHIFT = 38;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POWER_SAVE_ENABLE = 2'd0,
		REG_IDLE_TIMEOUT_SEC  = 2'd1,
		REG_DISPLAY_ENABLE    = 2'd2,
		REG_DISPLAY_OFF_SEC   = 2'd3
	} sed_reg_t;

	typedef enum logic [2:0] {
		RSN_OFF        = 3'd0,
		RSN_AP         = 3'd1,
		RSN_MOVING     = 3'd2,
		RSN_WEB        = 3'd3,
		RSN_RECENT     = 3'd4,
		RSN_DISPLAY    = 3'd5,
		RSN_EVENT_SOON = 3'd6,
		RSN_READY      = 3'd7
	} sed_reason_t;

	typedef struct packed {
		logic                power_save_enable;
		logic [15:0]         idle_timeout_sec;
		logic                display_enable;
		logic [MS_LIM_W-1:0] idle_ms;
		logic [MS_LIM_W-1:0] grace_ms;
	} sed_cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic [31:0] last_client_ms;
		logic        ap_mode;
		logic        servo_moving;
		logic        display_should_wake;
		logic        clock_valid;
		logic [16:0] seconds_of_day;
		logic        next_valid;
		logic [4:0]  next_hour;
		logic [5:0]  next_minute;
		logic [10:0] fallback_minutes;
		logic [31:0] last_touch_ms;
		logic        sleep_armed;
	} sed_item_t;

	typedef struct packed {
		sed_reason_t         reason;
		logic                countdown_valid;
		logic [MS_LIM_W-1:0] remain_ms;
		logic                low_power;
		logic                display_stay_awake;
		logic                enter_sleep;
		logic [SECS_W-1:0]   wake_sec;
	} sed_mid_t;

	typedef struct packed {
		logic [2:0]        sleep_reason;
		logic              countdown_valid;
		logic [15:0]       countdown_sec;
		logic              cpu_low_power;
		logic              periph_low_power;
		logic              display_stay_awake;
		logic              enter_sleep;
		logic [WAKE_W-1:0] wake_after_us;
	} sed_rsp_t;

endpackage

FILE: hdl/sed_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the tick and decision transactions.
// Widths follow the field list of the block; no package dependency.
interface sed_req_if;
	logic        valid;
	logic        ready;
	logic        interaction;
	logic [31:0] now_ms;
	logic [31:0] last_client_ms;
	logic        ap_mode;
	logic        servo_moving;
	logic        display_should_wake;
	logic        clock_valid;
	logic [16:0] seconds_of_day;
	logic        next_valid;
	logic [4:0]  next_hour;
	logic [5:0]  next_minute;
	logic [10:0] fallback_minutes;

	modport source (
		output valid, interaction, now_ms, last_client_ms, ap_mode, servo_moving,
			display_should_wake, clock_valid, seconds_of_day, next_valid,
			next_hour, next_minute, fallback_minutes,
		input  ready
	);
	modport sink (
		input  valid, interaction, now_ms, last_client_ms, ap_mode, servo_moving,
			display_should_wake, clock_valid, seconds_of_day, next_valid,
			next_hour, next_minute, fallback_minutes,
		output ready
	);
endinterface

interface sed_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  sleep_reason;
	logic        countdown_valid;
	logic [15:0] countdown_sec;
	logic        cpu_low_power;
	logic        periph_low_power;
	logic        display_stay_awake;
	logic        enter_sleep;
	logic [35:0] wake_after_us;

	modport source (
		output valid, sleep_reason, countdown_valid, countdown_sec, cpu_low_power,
			periph_low_power, display_stay_awake, enter_sleep, wake_after_us,
		input  ready
	);
	modport sink (
		input  valid, sleep_reason, countdown_valid, countdown_sec, cpu_low_power,
			periph_low_power, display_stay_awake, enter_sleep, wake_after_us,
		output ready
	);
endinterface

FILE: hdl/sed_cfg.sv
`timescale 1ns / 1ps
// Configuration registers with the millisecond limits derived at write time.
// Depends on sed_pkg.
module sed_cfg
	import sed_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] data,
	output sed_cfg_t              cfg
);

	logic                power_save_enable_q;
	logic [15:0]         idle_timeout_sec_q;
	logic                display_enable_q;
	logic [MS_LIM_W-1:0] idle_ms_q;
	logic [MS_LIM_W-1:0] grace_ms_q;
	logic [MS_LIM_W-1:0] data_ms;

	assign data_ms = MS_LIM_W'(data) * MS_LIM_W'(1000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_save_enable_q <= 1'b0;
			idle_timeout_sec_q  <= IDLE_TIMEOUT_RST;
			display_enable_q    <= 1'b1;
			idle_ms_q           <= MS_LIM_W'(IDLE_TIMEOUT_RST) * MS_LIM_W'(1000);
			grace_ms_q          <= MS_LIM_W'(DISP_OFF_RST) * MS_LIM_W'(1000);
		end else if (wr_en) begin
			unique case (sed_reg_t'(index))
				REG_POWER_SAVE_ENABLE: power_save_enable_q <= data[0];
				REG_IDLE_TIMEOUT_SEC: begin
					idle_timeout_sec_q <= data;
					idle_ms_q          <= data_ms;
				end
				REG_DISPLAY_ENABLE:    display_enable_q <= data[0];
				REG_DISPLAY_OFF_SEC:   grace_ms_q <= data_ms;
			endcase
		end
	end

	assign cfg.power_save_enable = power_save_enable_q;
	assign cfg.idle_timeout_sec  = idle_timeout_sec_q;
	assign cfg.display_enable    = display_enable_q;
	assign cfg.idle_ms           = idle_ms_q;
	assign cfg.grace_ms          = grace_ms_q;

endmodule

FILE: hdl/sed_eval.sv
`timescale 1ns / 1ps
// First logic stage: elapsed times, event distance, worthiness and flags.
// Depends on sed_pkg.
module sed_eval
	import sed_pkg::*;
(
	input  sed_item_t item,
	input  sed_cfg_t  cfg,
	output sed_mid_t  mid
);

	logic [31:0]          el_touch;
	logic [31:0]          el_web;
	logic                 recent;
	logic                 web;
	logic [MS_LIM_W-1:0]  rem_touch;
	logic [MS_LIM_W-1:0]  rem_web;
	logic [SECS_W-1:0]    ev_tod;
	logic [SECS_W-1:0]    fb_secs;
	logic signed [19:0]   diff;
	logic signed [19:0]   day_adj;
	logic                 secs_pos;
	logic [SECS_W-1:0]    secs_val;
	logic                 worth;
	logic                 pse;
	logic                 cd_valid;

	always_comb begin
		el_touch  = item.now_ms - item.last_touch_ms;
		el_web    = item.now_ms - item.last_client_ms;
		recent    = el_touch < 32'(cfg.idle_ms);
		web       = el_web < 32'(cfg.idle_ms);
		// A remainder is only nonzero while the elapsed time is below the limit,
		// so the low bits of the elapsed time are all that matter there.
		rem_touch = recent ? cfg.idle_ms - el_touch[MS_LIM_W-1:0] : '0;
		rem_web   = web ? cfg.idle_ms - el_web[MS_LIM_W-1:0] : '0;

		ev_tod  = SECS_W'(item.next_hour) * SECS_W'(3600)
			+ SECS_W'(item.next_minute) * SECS_W'(60);
		fb_secs = SECS_W'(item.fallback_minutes) * SECS_W'(60);
		diff    = signed'({3'b000, ev_tod}) - signed'({3'b000, item.seconds_of_day});
		day_adj = (diff <= 20'sd0) ? diff + DAY_S : diff;

		// A non-positive distance means no event is known or the fallback time is zero.
		if (!item.next_valid) begin
			secs_pos = 1'b0;
			secs_val = '0;
		end else if (!item.clock_valid) begin
			secs_pos = fb_secs != '0;
			secs_val = fb_secs;
		end else begin
			secs_pos = day_adj > 20'sd0;
			secs_val = day_adj[SECS_W-1:0];
		end
		worth = !secs_pos || (secs_val >= WORTH_MIN_S);

		pse      = cfg.power_save_enable;
		cd_valid = pse && !item.ap_mode && !item.servo_moving && worth;

		mid.countdown_valid = cd_valid;
		if (!cd_valid)
			mid.remain_ms = '0;
		else
			mid.remain_ms = (rem_touch > rem_web) ? rem_touch : rem_web;

		if (!pse)                          mid.reason = RSN_OFF;
		else if (item.ap_mode)             mid.reason = RSN_AP;
		else if (item.servo_moving)        mid.reason = RSN_MOVING;
		else if (web)                      mid.reason = RSN_WEB;
		else if (recent)                   mid.reason = RSN_RECENT;
		else if (item.display_should_wake) mid.reason = RSN_DISPLAY;
		else if (!worth)                   mid.reason = RSN_EVENT_SOON;
		else                               mid.reason = RSN_READY;

		mid.low_power = pse && !item.ap_mode && !item.servo_moving
			&& !item.display_should_wake;
		mid.display_stay_awake = cfg.display_enable
			&& (!pse || item.servo_moving || el_touch < 32'(cfg.grace_ms));
		mid.enter_sleep = pse && item.sleep_armed && !item.servo_moving
			&& !item.ap_mode && worth && !recent && !web;

		if (!secs_pos)
			mid.wake_sec = (SECS_W'(cfg.idle_timeout_sec) > FALLBACK_MIN_S)
				? SECS_W'(cfg.idle_timeout_sec) : FALLBACK_MIN_S;
		else if (secs_val >= WAKE_MARGIN_S + WAKE_FLOOR_S)
			mid.wake_sec = secs_val - WAKE_MARGIN_S;
		else
			mid.wake_sec = WAKE_FLOOR_S;
	end

endmodule

FILE: hdl/sed_fin.sv
`timescale 1ns / 1ps
// Second logic stage: countdown in whole seconds and wake delay in microseconds.
// Depends on sed_pkg.
module sed_fin
	import sed_pkg::*;
(
	input  sed_mid_t mid,
	output sed_rsp_t rsp
);

	logic [MS_LIM_W+28:0] quot_prod;
	logic [SECS_W+19:0]   wake_prod;

	always_comb begin
		// Division by 1000 through the scaled reciprocal.
		quot_prod = (MS_LIM_W+29)'(mid.remain_ms) * (MS_LIM_W+29)'(RECIP_1000);
		wake_prod = (SECS_W+20)'(mid.wake_sec) * (SECS_W+20)'(1000000);

		rsp.sleep_reason       = mid.reason;
		rsp.countdown_valid    = mid.countdown_valid;
		rsp.countdown_sec      = quot_prod[RECIP_SHIFT +: 16];
		rsp.cpu_low_power      = mid.low_power;
		rsp.periph_low_power   = mid.low_power;
		rsp.display_stay_awake = mid.display_stay_awake;
		rsp.enter_sleep        = mid.enter_sleep;
		rsp.wake_after_us      = wake_prod[WAKE_W-1:0];
	end

endmodule

FILE: hdl/sleep_entry_decision_core.sv
`timescale 1ns / 1ps
// Sleep-entry decision core: input register, two logic stages with a register between them, result register.
// A tick passes the input, middle and result registers in order; the result register offers it.
// Throughput: one tick per cycle, limited only by the result consumer.
// Reset: all pipeline stages empty, last touch time and sleep arm cleared,
// configuration registers at their defaults. Depends on sed_pkg and sed_ifs.
module sleep_entry_decision_core
	import sed_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	sed_req_if.sink               req,
	sed_rsp_if.source             rsp
);

	sed_cfg_t  cfg;
	sed_item_t item_s1;
	sed_mid_t  mid_comb;
	sed_mid_t  mid_s2;
	sed_rsp_t  rsp_comb;
	sed_rsp_t  rsp_s3;
	logic      v_s1, v_s2, v_s3;
	logic      ld_s1, ld_s2, ld_s3;
	logic      accept;
	logic [31:0] last_touch_q;
	logic        sleep_armed_q;

	sed_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// Each stage loads when it is empty or when its contents move on.
	assign ld_s3  = !v_s3 || rsp.ready;
	assign ld_s2  = !v_s2 || ld_s3;
	assign ld_s1  = !v_s1 || ld_s2;
	assign req.ready = ld_s1;
	assign accept = req.valid && ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			last_touch_q  <= '0;
			sleep_armed_q <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= req.valid;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= v_s2;
			if (accept && req.interaction) begin
				last_touch_q  <= req.now_ms;
				sleep_armed_q <= 1'b1;
			end
		end
	end

	// The touch state an item sees already includes its own interaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.now_ms              <= req.now_ms;
			item_s1.last_client_ms      <= req.last_client_ms;
			item_s1.ap_mode             <= req.ap_mode;
			item_s1.servo_moving        <= req.servo_moving;
			item_s1.display_should_wake <= req.display_should_wake;
			item_s1.clock_valid         <= req.clock_valid;
			item_s1.seconds_of_day      <= req.seconds_of_day;
			item_s1.next_valid          <= req.next_valid;
			item_s1.next_hour           <= req.next_hour;
			item_s1.next_minute         <= req.next_minute;
			item_s1.fallback_minutes    <= req.fallback_minutes;
			item_s1.last_touch_ms       <= req.interaction ? req.now_ms : last_touch_q;
			item_s1.sleep_armed         <= req.interaction || sleep_armed_q;
		end
		if (ld_s2 && v_s1) mid_s2 <= mid_comb;
		if (ld_s3 && v_s2) rsp_s3 <= rsp_comb;
	end

	sed_eval u_eval (
		.item (item_s1),
		.cfg  (cfg),
		.mid  (mid_comb)
	);

	sed_fin u_fin (
		.mid (mid_s2),
		.rsp (rsp_comb)
	);

	assign rsp.valid              = v_s3;
	assign rsp.sleep_reason       = rsp_s3.sleep_reason;
	assign rsp.countdown_valid    = rsp_s3.countdown_valid;
	assign rsp.countdown_sec      = rsp_s3.countdown_sec;
	assign rsp.cpu_low_power      = rsp_s3.cpu_low_power;
	assign rsp.periph_low_power   = rsp_s3.periph_low_power;
	assign rsp.display_stay_awake = rsp_s3.display_stay_awake;
	assign rsp.enter_sleep        = rsp_s3.enter_sleep;
	assign rsp.wake_after_us      = rsp_s3.wake_after_us;

	a_arm_from_touch: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sleep_armed_q) |-> $past(req.valid && req.ready && req.interaction))
		else $error("sleep arm set without an interaction transaction");

	a_enter_reason: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.enter_sleep) |->
			(rsp.sleep_reason == RSN_READY || rsp.sleep_reason == RSN_DISPLAY))
		else $error("sleep entry with a blocking reason");

	a_countdown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.countdown_valid) |-> (rsp.countdown_sec == 16'd0))
		else $error("countdown nonzero while not applicable");

	a_low_power_reason: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.cpu_low_power) |->
			(rsp.sleep_reason != RSN_OFF && rsp.sleep_reason != RSN_AP
			&& rsp.sleep_reason != RSN_MOVING))
		else $error("low power requested while power save is blocked");

endmodule
